/* rtl/etr_pkg.sv */
// ----------------------------------------------------------------------------
// etr_pkg
// Shared types and constants of the edge triggered trace recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package etr_pkg;

    localparam int DEPTH   = 128;
    localparam int POST    = 64;
    localparam int AW      = $clog2(DEPTH);
    localparam int PCW     = $clog2(POST + 1);
    // wide enough for a ring position plus a 7-bit read index
    localparam int SLOT_W  = 9;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_REARM = 2'd2;

    localparam logic [1:0] STAT_ARMED = 2'd0;
    localparam logic [1:0] STAT_TRIG  = 2'd1;
    localparam logic [1:0] STAT_DONE  = 2'd2;

    typedef enum logic [2:0] {
        S_ARMED = 3'b001,
        S_TRIG  = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic               run_req;
        logic               moe;
        logic               hard_fault;
        logic               bridge_req;
        logic               angle_ok;
        logic signed [15:0] current_reference;
        logic signed [15:0] current_target;
        logic [63:0]        telemetry;
        logic [6:0]         read_index;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         capture_status;
        logic [7:0]         capture_number;
        logic [7:0]         samples_held;
        logic [6:0]         trigger_cause;
        logic [6:0]         trigger_age_index;
        logic [63:0]        read_telemetry;
        logic signed [15:0] read_reference;
        logic signed [15:0] read_target;
        logic [6:0]         read_events;
        logic [4:0]         read_flags;
    } t_out;

    typedef struct packed {
        logic [4:0]  flags;
        logic [6:0]  events;
        logic [15:0] target;
        logic [15:0] reference;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef struct packed {
        logic       accepted;
        logic       rd_ok;
        logic [1:0] capture_status;
        logic [7:0] capture_number;
        logic [7:0] samples_held;
        logic [6:0] trigger_cause;
        logic [6:0] trigger_age_index;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/etr_ram.sv */
// ----------------------------------------------------------------------------
// etr_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/etr_ctrl.sv */
// ----------------------------------------------------------------------------
// etr_ctrl
// Recorder control: edge detection, trigger state, ring pointers, valid bits
// and store addressing for one item per cycle while i_acc is high.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_ctrl
    import etr_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire t_in           i_item,
    output t_stat              o_stat,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output t_meta              o_wmeta,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr
);

    t_state            r_state, n_state, c_state;
    logic              r_primed, n_primed, c_primed;
    logic [4:0]        r_prev, n_prev, c_prev;
    logic [AW-1:0]     r_wp, n_wp, c_wp;
    logic [AW-1:0]     r_trig, n_trig, c_trig;
    logic [PCW-1:0]    r_post, n_post, c_post;
    logic [6:0]        r_cause, n_cause, c_cause;
    logic [7:0]        r_gen, n_gen, c_gen;
    logic              r_pending, n_pending;
    logic [DEPTH-1:0]  r_valid, n_valid, c_valid;

    logic              clr;
    logic [4:0]        lv;
    logic [4:0]        rise;
    logic [4:0]        fall;
    logic [6:0]        ev;
    logic [4:0]        flags;
    logic [PCW-1:0]    post_inc;
    logic [SLOT_W-1:0] slot_sum;
    logic [AW-1:0]     slot;
    logic              idx_ok;
    logic [AW:0]       age_wide;
    logic [AW-1:0]     age;

    assign lv    = {i_item.hard_fault, |i_item.current_target,
                    |i_item.current_reference, i_item.moe, i_item.run_req};
    assign flags = {i_item.angle_ok, i_item.hard_fault, i_item.moe,
                    i_item.bridge_req, i_item.run_req};

    assign slot_sum = SLOT_W'(r_wp) + SLOT_W'(i_item.read_index);
    assign slot     = (slot_sum >= SLOT_W'(DEPTH)) ? AW'(slot_sum - SLOT_W'(DEPTH))
                                                   : AW'(slot_sum);
    assign idx_ok   = SLOT_W'(i_item.read_index) < SLOT_W'(DEPTH);

    always_comb begin
        clr      = (i_item.op == OP_TICK) && r_pending;
        c_state  = clr ? S_ARMED : r_state;
        c_primed = clr ? 1'b0 : r_primed;
        c_prev   = clr ? '0 : r_prev;
        c_wp     = clr ? '0 : r_wp;
        c_trig   = clr ? '0 : r_trig;
        c_post   = clr ? '0 : r_post;
        c_cause  = clr ? '0 : r_cause;
        c_gen    = clr ? r_gen + 8'd1 : r_gen;
        c_valid  = clr ? '0 : r_valid;

        rise     = lv & ~c_prev;
        fall     = ~lv & c_prev;
        ev       = {rise[4], fall[1], fall[2], fall[3], rise[2], rise[1], rise[0]};
        post_inc = c_post + PCW'(1);

        n_state   = c_state;
        n_primed  = c_primed;
        n_prev    = c_prev;
        n_wp      = c_wp;
        n_trig    = c_trig;
        n_post    = c_post;
        n_cause   = c_cause;
        n_gen     = c_gen;
        n_valid   = c_valid;
        n_pending = clr ? 1'b0 : r_pending;

        o_stat.accepted = 1'b0;
        o_stat.rd_ok    = 1'b0;
        o_we            = 1'b0;
        o_waddr         = c_wp;
        o_wmeta.flags     = flags;
        o_wmeta.events    = ev;
        o_wmeta.target    = i_item.current_target;
        o_wmeta.reference = i_item.current_reference;
        o_re            = 1'b0;
        o_raddr         = slot;

        case (i_item.op)
            OP_TICK: begin
                if (c_state != S_DONE) begin
                    n_prev = lv;
                    if (!c_primed) begin
                        n_primed = 1'b1;
                    end else begin
                        o_we            = i_acc;
                        n_valid[c_wp]   = 1'b1;
                        n_wp            = (c_wp == AW'(DEPTH - 1)) ? '0 : c_wp + AW'(1);
                        o_stat.accepted = 1'b1;
                        if (c_state == S_ARMED && ev != '0) begin
                            n_state = S_TRIG;
                            n_trig  = c_wp;
                            n_post  = '0;
                            n_cause = ev;
                        end else if (c_state == S_TRIG) begin
                            n_post = post_inc;
                            if (post_inc >= PCW'(POST)) begin
                                n_state = S_DONE;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                if (r_state == S_DONE && idx_ok) begin
                    o_re            = i_acc;
                    o_stat.rd_ok    = r_valid[slot];
                    o_stat.accepted = 1'b1;
                end
            end
            OP_REARM: begin
                if (r_state == S_DONE && !r_pending) begin
                    n_pending       = 1'b1;
                    o_stat.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase

        age_wide = (n_trig >= n_wp) ? (AW + 1)'(n_trig - n_wp)
                 : (AW + 1)'(n_trig) + (AW + 1)'(DEPTH) - (AW + 1)'(n_wp);
        age      = AW'(age_wide);

        case (n_state)
            S_ARMED: begin
                o_stat.capture_status = STAT_ARMED;
                o_stat.samples_held   = 8'd0;
            end
            S_TRIG: begin
                o_stat.capture_status = STAT_TRIG;
                o_stat.samples_held   = 8'(n_post) + 8'd1;
            end
            S_DONE: begin
                o_stat.capture_status = STAT_DONE;
                o_stat.samples_held   = 8'(DEPTH);
            end
            default: begin
                o_stat.capture_status = STAT_ARMED;
                o_stat.samples_held   = 8'd0;
            end
        endcase
        o_stat.capture_number    = n_gen;
        o_stat.trigger_cause     = n_cause;
        o_stat.trigger_age_index = 7'(age);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ARMED;
            r_primed  <= 1'b0;
            r_prev    <= '0;
            r_wp      <= '0;
            r_trig    <= '0;
            r_post    <= '0;
            r_cause   <= '0;
            r_gen     <= 8'd1;
            r_pending <= 1'b0;
            r_valid   <= '0;
        end else if (i_acc) begin
            r_state   <= n_state;
            r_primed  <= n_primed;
            r_prev    <= n_prev;
            r_wp      <= n_wp;
            r_trig    <= n_trig;
            r_post    <= n_post;
            r_cause   <= n_cause;
            r_gen     <= n_gen;
            r_pending <= n_pending;
            r_valid   <= n_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/edge_triggered_trace_recorder.sv */
// ----------------------------------------------------------------------------
// edge_triggered_trace_recorder
// Ring buffer trace recorder with pre/post trigger capture.
//
// Input channel i_valid / o_stall carries one item (tick, read or rearm);
// output channel o_valid / i_stall returns exactly one result per item.
// A tick, save the priming tick and any tick once the capture is
// complete, writes one sample into the telemetry and meta stores; a read
// returns a stored sample in age order once the capture is complete.
// Items are taken one per cycle while o_stall is low. Each result passes
// through the registered store read port and then the output register.
// The receiver may stall at any time; the result and the item behind it
// are held, and o_stall rises only when both stages are occupied.
// Reset is synchronous and needs no clearing pass: per entry valid bits
// are cleared at once, so the recorder is armed with capture id one in
// the first cycle after reset. A rearm clears them on the next tick.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_triggered_trace_recorder
    import etr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_item,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_result
);

    t_stat          stat;
    logic           acc;
    logic           we;
    logic [AW-1:0]  waddr;
    t_meta          wmeta;
    logic           re;
    logic [AW-1:0]  raddr;
    logic [63:0]    rd_tel;
    logic [META_W-1:0] rd_meta_bits;
    t_meta          rd_meta;
    logic           s1_adv;

    logic           r_s1_vld;
    t_stat          r_s1_stat;
    logic           r_out_vld;
    t_out           r_out;

    assign s1_adv  = !r_out_vld || !i_stall;
    assign o_stall = r_s1_vld && !s1_adv;
    assign acc     = i_valid && !o_stall;
    assign rd_meta = t_meta'(rd_meta_bits);

    etr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (i_item),
        .o_stat  (stat),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wmeta (wmeta),
        .o_re    (re),
        .o_raddr (raddr)
    );

    etr_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_tel_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.telemetry),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_tel)
    );

    etr_ram #(
        .WIDTH (META_W),
        .DEPTH (DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wmeta),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_meta_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_stat <= stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out.accepted          <= r_s1_stat.accepted;
            r_out.capture_status    <= r_s1_stat.capture_status;
            r_out.capture_number    <= r_s1_stat.capture_number;
            r_out.samples_held      <= r_s1_stat.samples_held;
            r_out.trigger_cause     <= r_s1_stat.trigger_cause;
            r_out.trigger_age_index <= r_s1_stat.trigger_age_index;
            r_out.read_telemetry    <= r_s1_stat.rd_ok ? rd_tel : 64'd0;
            r_out.read_reference    <= r_s1_stat.rd_ok ? rd_meta.reference : 16'd0;
            r_out.read_target       <= r_s1_stat.rd_ok ? rd_meta.target : 16'd0;
            r_out.read_events       <= r_s1_stat.rd_ok ? rd_meta.events : 7'd0;
            r_out.read_flags        <= r_s1_stat.rd_ok ? rd_meta.flags : 5'd0;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge triggered trace recorder. A queue of
// items (directed first, then capture sequences with random content and
// noise) feeds a clocked driver; every accepted item runs through a predictor
// of the recorder, and a clocked monitor compares each result, field by field,
// with the oldest expected one. Both sides idle at random until the last phase.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import etr_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         PHASE_ITEMS = 545;

    typedef struct {
        t_in item;
        bit  drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_item  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_result;

    edge_triggered_trace_recorder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    t_pending pending_items[$];
    t_out     expected_results[$];
    int       mismatches    = 0;
    int       queued_count  = 0;
    int       quiet_cycles  = 0;
    int       send_idle_pct = 34;
    int       recv_idle_pct = 80;

    // predicted recorder state
    logic [63:0] tel_mem [DEPTH];
    t_meta       meta_mem [DEPTH];
    bit          live [DEPTH];
    bit          touched [DEPTH];
    int          wr_pos;
    int          trig_pos;
    int          post_cnt;
    logic [1:0]  rec_state;
    logic [7:0]  capture_id;
    logic [6:0]  cause;
    bit          rearm_req;
    bit          primed;
    logic [4:0]  last_lv;

    t_pending next_up;
    t_out     want;
    int       k;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void wipe_capture();
        for (int j = 0; j < DEPTH; j++) live[j] = 1'b0;
        wr_pos    = 0;
        trig_pos  = 0;
        post_cnt  = 0;
        rec_state = STAT_ARMED;
        cause     = '0;
        rearm_req = 1'b0;
        primed    = 1'b0;
        last_lv   = '0;
    endfunction

    function automatic t_out trace_predict(input t_in it);
        t_out       res;
        logic [4:0] lv;
        logic [4:0] rise;
        logic [4:0] fall;
        logic [6:0] ev;
        t_meta      m;
        int         slot;
        res = '0;
        case (it.op)
            OP_TICK: begin
                if (rearm_req) begin
                    wipe_capture();
                    capture_id = capture_id + 8'd1;
                end
                if (rec_state != STAT_DONE) begin
                    lv = {it.hard_fault, it.current_target != 0,
                          it.current_reference != 0, it.moe, it.run_req};
                    rise = lv & ~last_lv;
                    fall = ~lv & last_lv;
                    ev = {rise[4], fall[1], fall[2], fall[3], rise[2], rise[1], rise[0]};
                    last_lv = lv;
                    if (!primed) begin
                        primed = 1'b1;
                    end else begin
                        m.reference = it.current_reference;
                        m.target    = it.current_target;
                        m.events    = ev;
                        m.flags     = {it.angle_ok, it.hard_fault, it.moe,
                                       it.bridge_req, it.run_req};
                        tel_mem[wr_pos]  = it.telemetry;
                        meta_mem[wr_pos] = m;
                        live[wr_pos]     = 1'b1;
                        touched[wr_pos]  = 1'b1;
                        if (rec_state == STAT_ARMED && ev != 0) begin
                            rec_state = STAT_TRIG;
                            trig_pos  = wr_pos;
                            post_cnt  = 0;
                            cause     = ev;
                        end else if (rec_state == STAT_TRIG) begin
                            post_cnt++;
                            if (post_cnt >= POST) rec_state = STAT_DONE;
                        end
                        wr_pos = (wr_pos + 1) % DEPTH;
                        res.accepted = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (rec_state == STAT_DONE && int'(it.read_index) < DEPTH) begin
                    slot = (wr_pos + int'(it.read_index)) % DEPTH;
                    if (live[slot]) begin
                        res.read_telemetry = tel_mem[slot];
                        res.read_reference = meta_mem[slot].reference;
                        res.read_target    = meta_mem[slot].target;
                        res.read_events    = meta_mem[slot].events;
                        res.read_flags     = meta_mem[slot].flags;
                    end
                    res.accepted = 1'b1;
                end
            end
            OP_REARM: begin
                if (rec_state == STAT_DONE && !rearm_req) begin
                    rearm_req    = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        res.capture_status    = rec_state;
        res.capture_number    = capture_id;
        res.samples_held      = (rec_state == STAT_DONE) ? 8'(DEPTH) :
                                (rec_state == STAT_TRIG) ? 8'(post_cnt + 1) : 8'd0;
        res.trigger_cause     = cause;
        res.trigger_age_index = 7'((trig_pos + DEPTH - wr_pos) % DEPTH);
        return res;
    endfunction

    function automatic logic signed [15:0] any_nonzero();
        logic signed [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            2: v = -16'sd1;
            3: v = 16'sd1;
            default: v = 16'($urandom);
        endcase
        if (v == 0) v = 16'sd1;
        return v;
    endfunction

    // levels: run, moe, reference nonzero, target nonzero, fault
    function automatic t_in make_tick(input logic [4:0] lv);
        t_in it;
        it.op                = OP_TICK;
        it.run_req           = lv[0];
        it.moe               = lv[1];
        it.current_reference = lv[2] ? any_nonzero() : 16'sd0;
        it.current_target    = lv[3] ? any_nonzero() : 16'sd0;
        it.hard_fault        = lv[4];
        it.bridge_req        = 1'($urandom_range(0, 1));
        it.angle_ok          = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: it.telemetry = '0;
            1: it.telemetry = '1;
            default: it.telemetry = {$urandom, $urandom};
        endcase
        it.read_index = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic t_in make_op(input logic [1:0] op);
        t_in it;
        it = make_tick(5'($urandom));
        it.op = op;
        if (op == OP_READ && $urandom_range(0, 3) == 0)
            it.read_index = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        return it;
    endfunction

    task automatic push_item(input t_in it, input bit drain);
        t_pending p;
        p.item  = it;
        p.drain = drain;
        pending_items.push_back(p);
        queued_count++;
    endtask

    // rearm, prime, quiet stretch, trigger, post ticks with noise, reads
    task automatic queue_capture();
        logic [4:0] lv;
        logic [4:0] flip;
        int         n;
        push_item(make_op(OP_REARM), $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0) begin
            push_item(make_op(OP_READ), 1'b0);
            push_item(make_op(OP_REARM), 1'b0);
        end
        lv = 5'($urandom);
        push_item(make_tick(lv), 1'b0);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
        repeat (n) push_item(make_tick(lv), 1'b0);
        flip = 5'($urandom_range(0, 31)) | ($urandom_range(0, 1) ? 5'b00010 : 5'b00100);
        push_item(make_tick(lv ^ flip), $urandom_range(0, 3) == 0);
        n = POST + $urandom_range(0, 6);
        while (n > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(make_op(2'($urandom_range(0, 3))), 1'b0);
            end else begin
                push_item(make_tick(5'($urandom)), 1'b0);
                n--;
            end
        end
        n = $urandom_range(3, 20);
        repeat (n) push_item(make_op(OP_READ), $urandom_range(0, 19) == 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(trace_predict(i_item));
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 &&
                    !(pending_items[0].drain && expected_results.size() != 0) &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_up = pending_items.pop_front();
                    // a complete capture is only read at slots written at some point
                    if (next_up.item.op == OP_READ && rec_state == STAT_DONE) begin
                        for (k = 0; k < DEPTH &&
                             !touched[(wr_pos + int'(next_up.item.read_index)) % DEPTH]; k++)
                            next_up.item.read_index = next_up.item.read_index + 7'd1;
                    end
                    i_item  <= next_up.item;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: got %h", $time, o_result);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, o_result.accepted);
                    check_field("capture_status", want.capture_status,
                                o_result.capture_status);
                    check_field("capture_number", want.capture_number,
                                o_result.capture_number);
                    check_field("samples_held", want.samples_held, o_result.samples_held);
                    check_field("trigger_cause", want.trigger_cause, o_result.trigger_cause);
                    check_field("trigger_age_index", want.trigger_age_index,
                                o_result.trigger_age_index);
                    check_field("read_telemetry", want.read_telemetry,
                                o_result.read_telemetry);
                    check_field("read_reference", want.read_reference,
                                o_result.read_reference);
                    check_field("read_target", want.read_target, o_result.read_target);
                    check_field("read_events", want.read_events, o_result.read_events);
                    check_field("read_flags", want.read_flags, o_result.read_flags);
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t no progress for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_in d;
        wipe_capture();
        capture_id = 8'd1;

        // before any capture: reads, rearm and unknown op are refused
        d = make_op(OP_READ);
        d.read_index = 7'd0;
        push_item(d, 1'b0);
        d = make_op(OP_READ);
        d.read_index = 7'd127;
        push_item(d, 1'b0);
        push_item(make_op(OP_REARM), 1'b0);
        push_item(make_op(OP_UNUSED), 1'b0);
        // priming tick
        d = make_tick(5'b01000);
        d.current_target = 16'sh7fff;
        d.telemetry = '1;
        push_item(d, 1'b0);
        // all rising events at once, target falls to zero
        d = make_tick(5'b10111);
        d.current_reference = 16'sh8000;
        d.bridge_req        = 1'b1;
        d.angle_ok          = 1'b1;
        d.telemetry = '0;
        push_item(d, 1'b0);
        // moe and reference fall
        d = make_tick(5'b11001);
        d.current_target = 16'sh8000;
        push_item(d, 1'b0);
        push_item(make_tick(5'b00000), 1'b0);
        push_item(make_op(OP_READ), 1'b1);
        push_item(make_op(OP_REARM), 1'b0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 34 : 0;
            while (queued_count < 10 + PHASE_ITEMS * (phase + 1)) queue_capture();
            while (pending_items.size() != 0 || i_valid || expected_results.size() != 0)
                @(posedge i_clk);
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/etr_pkg.sv
rtl/etr_ram.sv
rtl/etr_ctrl.sv
rtl/edge_triggered_trace_recorder.sv
tb/testbench.sv
